/* sv/fnrs_pkg.sv */
// Shared types and constants for the fixed-radius neighbor search block.
// No dependencies; fnrs_isqrt and the top level import this package.
`default_nettype none

package fnrs_pkg;

   // Store geometry and field widths.
   localparam int MAX_POINTS    = 4096;
   localparam int PTR_W         = $clog2(MAX_POINTS);
   localparam int ACTIVE_W      = PTR_W + 1;
   localparam int CNT_W         = PTR_W + 1;
   localparam int OUT_CNT_W     = 12;
   localparam int MAX_NEIGHBORS = 63;
   localparam int COORD_W       = 16;
   localparam int POINT_W       = 3 * COORD_W;
   localparam int DIFF_W        = COORD_W + 1;
   localparam int SQ_W          = 2 * COORD_W;
   localparam int D2_W          = SQ_W + 2;
   localparam int RADIUS_W      = 14;
   localparam int R2_W          = 2 * RADIUS_W;
   localparam int ROOT_W        = RADIUS_W;
   localparam int ALPHA_W       = 8;
   localparam int NUM_W         = RADIUS_W + ALPHA_W;
   localparam int CSR_INDEX_W   = 1;

   // Register reset values: radius 18.0 in Q8.6, 2500 active points.
   localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(1152);
   localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = ACTIVE_W'(2500);
   localparam logic [ALPHA_W-1:0]  ALPHA_SCALE  = ALPHA_W'(255);

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_RADIUS = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACTIVE = 1'b1;

   // Operation and result kind codes.
   localparam logic OP_LOAD      = 1'b0;
   localparam logic OP_QUERY     = 1'b1;
   localparam logic KIND_PAIR    = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   // Query sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CENTER,
      ST_SCAN,
      ST_PAIR_SQRT,
      ST_PAIR_EMIT,
      ST_MIN_SQRT,
      ST_DIVIDE,
      ST_SUM_EMIT
   } state_type;

endpackage

`default_nettype wire

/* sv/fnrs_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
`default_nettype none

module fnrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* sv/fnrs_isqrt.sv */
// Iterative floor square root, one result bit per cycle.
// Depends on fnrs_pkg for widths.
`default_nettype none

module fnrs_isqrt (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [fnrs_pkg::R2_W-1:0]     operand,
   output logic                               done,
   output logic      [fnrs_pkg::ROOT_W-1:0]   root
);
   import fnrs_pkg::*;

   localparam int STEP_W = $clog2(ROOT_W);
   localparam int REM_W  = ROOT_W + 3;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff;
   logic [R2_W-1:0]   op_ff;
   logic [REM_W-1:0]  rem_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [REM_W-1:0]  rem_sh;
   logic [REM_W-1:0]  trial;
   logic              take;

   // One digit step: bring down two operand bits and try the next root bit.
   always_comb begin
      rem_sh = {rem_ff[REM_W-3:0], op_ff[R2_W-1 -: 2]};
      trial  = REM_W'({root_ff, 2'b01});
      take   = rem_sh >= trial;
   end

   // Control: busy for ROOT_W steps, done pulses after the last.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
      end else if (busy_ff && step_ff == STEP_W'(ROOT_W - 1)) begin
         busy_in = 1'b0;
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Datapath.
   always_ff @(posedge clock) begin
      if (start) begin
         op_ff   <= operand;
         rem_ff  <= '0;
         root_ff <= '0;
         step_ff <= '0;
      end else if (busy_ff) begin
         op_ff   <= {op_ff[R2_W-3:0], 2'b00};
         rem_ff  <= take ? rem_sh - trial : rem_sh;
         root_ff <= {root_ff[ROOT_W-2:0], take};
         step_ff <= step_ff + STEP_W'(1);
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

`default_nettype wire

/* sv/fixed_radius_neighbor_search.sv */
// Fixed-radius neighbor search: a load writes one point into the point RAM. A query reads
// the center and scans the stored points (one stored point read per cycle from the point
// RAM while in the scan state), restarts the scan after each emitted pair and takes its
// square root, then ends with a summary (square root and divide). One transaction
// is in work at a time. Synchronous reset clears control state and restores the
// registers to radius 18.0 and 2500 active points; the point store is not cleared.
`default_nettype none

module fixed_radius_neighbor_search (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic                                 req_op,
   input  wire logic        [fnrs_pkg::PTR_W-1:0]    req_point_index,
   input  wire logic signed [fnrs_pkg::COORD_W-1:0]  req_coord_x,
   input  wire logic signed [fnrs_pkg::COORD_W-1:0]  req_coord_y,
   input  wire logic signed [fnrs_pkg::COORD_W-1:0]  req_coord_z,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic                                      rsp_kind,
   output logic             [fnrs_pkg::PTR_W-1:0]    rsp_center_index,
   output logic             [fnrs_pkg::PTR_W-1:0]    rsp_neighbor_index,
   output logic             [fnrs_pkg::ROOT_W-1:0]   rsp_min_distance,
   output logic             [fnrs_pkg::ALPHA_W-1:0]  rsp_alpha,
   output logic             [fnrs_pkg::OUT_CNT_W-1:0] rsp_neighbor_count,
   output logic                                      rsp_overflow,
   output logic                                      rsp_last,
   input  wire logic                                 csr_write_enable,
   input  wire logic        [fnrs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic        [fnrs_pkg::RADIUS_W-1:0] csr_wdata
);
   import fnrs_pkg::*;

   localparam int DIV_STEP_W = $clog2(NUM_W);
   localparam int DREM_W     = RADIUS_W + 1;

   state_type state_ff, state_in;

   // Configuration and per-query registers.
   logic [RADIUS_W-1:0] radius_ff;
   logic [ACTIVE_W-1:0] active_ff;
   logic [ACTIVE_W-1:0] n_act_ff;
   logic [R2_W-1:0]     r2_ff;
   logic [PTR_W-1:0]    center_ff;
   logic signed [COORD_W-1:0] cx_ff, cy_ff, cz_ff;
   logic [ACTIVE_W-1:0] scan_addr_ff, scan_addr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [R2_W-1:0]     dmin2_ff, dmin2_in;

   // Scan pipeline.
   logic                v1_ff, v2_ff, v3_ff;
   logic [PTR_W-1:0]    idx1_ff, idx2_ff, idx3_ff;
   logic signed [DIFF_W-1:0] dx_ff, dy_ff, dz_ff;
   logic [SQ_W-1:0]     sqx_ff, sqy_ff, sqz_ff;

   // Summary arithmetic.
   logic [PTR_W-1:0]    pair_idx_ff;
   logic [ROOT_W-1:0]   md_ff;
   logic [NUM_W-1:0]    num_ff;
   logic [DREM_W-1:0]   drem_ff;
   logic [ALPHA_W-1:0]  quot_ff;
   logic [DIV_STEP_W-1:0] dstep_ff;

   // Output register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_kind_ff;
   logic [PTR_W-1:0]    rsp_center_ff, rsp_neighbor_ff;
   logic [ROOT_W-1:0]   rsp_md_ff;
   logic [ALPHA_W-1:0]  rsp_alpha_ff;
   logic [OUT_CNT_W-1:0] rsp_count_ff;
   logic                rsp_overflow_ff, rsp_last_ff;

   logic                req_accept;
   logic                out_free;
   logic                issue;
   logic                hit;
   logic                pair_hit;
   logic                scan_done;
   logic                out_load;
   logic [D2_W-1:0]     d2;
   logic [PTR_W-1:0]    rd_addr;
   logic [POINT_W-1:0]  rd_data;
   logic signed [COORD_W-1:0] px, py, pz;
   logic                sqrt_start;
   logic [R2_W-1:0]     sqrt_operand;
   logic                sqrt_done;
   logic [ROOT_W-1:0]   sqrt_root;
   logic [ROOT_W-1:0]   md_cap;
   logic [DREM_W-1:0]   drem_sh;
   logic                dtake;
   logic [OUT_CNT_W-1:0] count_sat;

   assign req_stall  = state_ff != ST_IDLE;
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // Point store: load writes, queries read the center and then the scan.
   assign rd_addr = (state_ff == ST_IDLE) ? req_point_index : scan_addr_ff[PTR_W-1:0];

   fnrs_ram #(
      .WIDTH (POINT_W),
      .DEPTH (MAX_POINTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (req_accept && req_op == OP_LOAD),
      .wr_addr (req_point_index),
      .wr_data ({req_coord_x, req_coord_y, req_coord_z}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign px = rd_data[3*COORD_W-1 -: COORD_W];
   assign py = rd_data[2*COORD_W-1 -: COORD_W];
   assign pz = rd_data[COORD_W-1 -: COORD_W];

   // Final stage: distance sum and radius test.
   always_comb begin
      d2 = D2_W'(sqx_ff) + D2_W'(sqy_ff) + D2_W'(sqz_ff);
      hit       = v3_ff && d2 <= D2_W'(r2_ff);
      pair_hit  = hit && count_ff < CNT_W'(MAX_NEIGHBORS);
      issue     = state_ff == ST_SCAN && scan_addr_ff < n_act_ff;
      scan_done = state_ff == ST_SCAN && !issue && !v1_ff && !v2_ff && !v3_ff;
      md_cap    = (sqrt_root > radius_ff) ? radius_ff : sqrt_root;
      count_sat = (count_ff > CNT_W'(2**OUT_CNT_W - 1)) ? '1 : count_ff[OUT_CNT_W-1:0];
   end

   // Square root unit shared by pair distances and the summary minimum.
   assign sqrt_operand = pair_hit ? d2[R2_W-1:0] : dmin2_ff;

   fnrs_isqrt u_isqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (sqrt_start),
      .operand (sqrt_operand),
      .done    (sqrt_done),
      .root    (sqrt_root)
   );

   // Restoring divide step for the alpha value.
   always_comb begin
      drem_sh = {drem_ff[DREM_W-2:0], num_ff[NUM_W-1]};
      dtake   = drem_sh >= DREM_W'(radius_ff);
   end

   // Sequencer: next state and control.
   always_comb begin
      state_in     = state_ff;
      scan_addr_in = scan_addr_ff;
      count_in     = count_ff;
      dmin2_in     = dmin2_ff;
      sqrt_start   = 1'b0;
      out_load     = 1'b0;
      if (issue) begin
         scan_addr_in = scan_addr_ff + ACTIVE_W'(1);
      end
      if (hit) begin
         count_in = count_ff + CNT_W'(1);
         if (d2[R2_W-1:0] < dmin2_ff) begin
            dmin2_in = d2[R2_W-1:0];
         end
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && req_op == OP_QUERY) begin
               state_in = ST_CENTER;
            end
         end
         ST_CENTER: begin
            scan_addr_in = '0;
            count_in     = '0;
            dmin2_in     = r2_ff;
            state_in     = ST_SCAN;
         end
         ST_SCAN: begin
            if (pair_hit) begin
               sqrt_start   = 1'b1;
               scan_addr_in = ACTIVE_W'(idx3_ff) + ACTIVE_W'(1);
               state_in     = ST_PAIR_SQRT;
            end else if (scan_done) begin
               sqrt_start = 1'b1;
               state_in   = ST_MIN_SQRT;
            end
         end
         ST_PAIR_SQRT: begin
            if (sqrt_done) begin
               state_in = ST_PAIR_EMIT;
            end
         end
         ST_PAIR_EMIT: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_MIN_SQRT: begin
            if (sqrt_done) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (dstep_ff == DIV_STEP_W'(NUM_W - 1)) begin
               state_in = ST_SUM_EMIT;
            end
         end
         ST_SUM_EMIT: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         radius_ff    <= RADIUS_RESET;
         active_ff    <= ACTIVE_RESET;
         rsp_valid_ff <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_RADIUS: radius_ff <= csr_wdata;
               CSR_ACTIVE: active_ff <= csr_wdata[ACTIVE_W-1:0];
               default:    radius_ff <= radius_ff;
            endcase
         end
         // A pair hit flushes the pipeline; the scan restarts after that point.
         if (pair_hit) begin
            v1_ff <= 1'b0;
            v2_ff <= 1'b0;
            v3_ff <= 1'b0;
         end else begin
            v1_ff <= issue && scan_addr_ff != ACTIVE_W'(center_ff);
            v2_ff <= v1_ff;
            v3_ff <= v2_ff;
         end
      end
   end

   // Query setup, scan datapath and running statistics.
   always_ff @(posedge clock) begin
      scan_addr_ff <= scan_addr_in;
      count_ff     <= count_in;
      dmin2_ff     <= dmin2_in;
      if (req_accept) begin
         center_ff <= req_point_index;
         r2_ff     <= R2_W'(radius_ff) * R2_W'(radius_ff);
         n_act_ff  <= (active_ff > ACTIVE_W'(MAX_POINTS)) ? ACTIVE_W'(MAX_POINTS) : active_ff;
      end
      if (state_ff == ST_CENTER) begin
         cx_ff <= px;
         cy_ff <= py;
         cz_ff <= pz;
      end
      idx1_ff <= scan_addr_ff[PTR_W-1:0];
      idx2_ff <= idx1_ff;
      idx3_ff <= idx2_ff;
      dx_ff   <= DIFF_W'(px) - DIFF_W'(cx_ff);
      dy_ff   <= DIFF_W'(py) - DIFF_W'(cy_ff);
      dz_ff   <= DIFF_W'(pz) - DIFF_W'(cz_ff);
      sqx_ff  <= SQ_W'(dx_ff) * SQ_W'(dx_ff);
      sqy_ff  <= SQ_W'(dy_ff) * SQ_W'(dy_ff);
      sqz_ff  <= SQ_W'(dz_ff) * SQ_W'(dz_ff);
      if (pair_hit) begin
         pair_idx_ff <= idx3_ff;
      end
   end

   // Alpha divide: 255 * (radius - md) / radius, one quotient bit per cycle.
   always_ff @(posedge clock) begin
      if (state_ff == ST_MIN_SQRT && sqrt_done) begin
         md_ff    <= md_cap;
         num_ff   <= (NUM_W'(radius_ff - md_cap) << ALPHA_W) - NUM_W'(radius_ff - md_cap);
         drem_ff  <= '0;
         quot_ff  <= '0;
         dstep_ff <= '0;
      end else if (state_ff == ST_DIVIDE) begin
         num_ff   <= {num_ff[NUM_W-2:0], 1'b0};
         drem_ff  <= dtake ? drem_sh - DREM_W'(radius_ff) : drem_sh;
         quot_ff  <= {quot_ff[ALPHA_W-2:0], dtake};
         dstep_ff <= dstep_ff + DIV_STEP_W'(1);
      end
   end

   // Output register: a pair or the closing summary.
   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_center_ff <= center_ff;
         rsp_count_ff  <= count_sat;
         if (state_ff == ST_PAIR_EMIT) begin
            rsp_kind_ff     <= KIND_PAIR;
            rsp_neighbor_ff <= pair_idx_ff;
            rsp_md_ff       <= sqrt_root;
            rsp_alpha_ff    <= '0;
            rsp_overflow_ff <= 1'b0;
            rsp_last_ff     <= 1'b0;
         end else begin
            rsp_kind_ff     <= KIND_SUMMARY;
            rsp_neighbor_ff <= '0;
            rsp_md_ff       <= md_ff;
            rsp_alpha_ff    <= (radius_ff == '0) ? '0 : quot_ff;
            rsp_overflow_ff <= count_ff > CNT_W'(MAX_NEIGHBORS);
            rsp_last_ff     <= 1'b1;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_kind_ff;
   assign rsp_center_index   = rsp_center_ff;
   assign rsp_neighbor_index = rsp_neighbor_ff;
   assign rsp_min_distance   = rsp_md_ff;
   assign rsp_alpha          = rsp_alpha_ff;
   assign rsp_neighbor_count = rsp_count_ff;
   assign rsp_overflow       = rsp_overflow_ff;
   assign rsp_last           = rsp_last_ff;

endmodule

`default_nettype wire
